[src/wsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types, sizes, codes and index helpers of the work-stealing deque
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int CAPACITY      = 1024;
    localparam int PAYLOAD_WIDTH = 64;

    localparam int IDX_MOD = 2 * CAPACITY;
    localparam int IDX_W   = $clog2(IDX_MOD);
    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 64;
    localparam int ITEM_W   = 11;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_TAKE  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEAL = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] payload_in;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   payload_out;
        logic [ITEM_W-1:0]   item_count;
    } t_out_item;

    function automatic t_idx idx_inc(input t_idx i);
        return (i == t_idx'(IDX_MOD - 1)) ? '0 : t_idx'(i + 1'b1);
    endfunction

    function automatic t_idx idx_dec(input t_idx i);
        return (i == '0) ? t_idx'(IDX_MOD - 1) : t_idx'(i - 1'b1);
    endfunction

    // index is below twice the capacity, so one compare and subtract
    function automatic t_addr slot_of(input t_idx i);
        return (i >= t_idx'(CAPACITY)) ? t_addr'(i - t_idx'(CAPACITY)) : t_addr'(i);
    endfunction

endpackage

[src/work_stealing_deque.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// work_stealing_deque
// fixed-capacity chase-lev deque: push and take at bottom, steal at top
// ----------------------------------------------------------------------------
//  channel  | valid       | ready       | beat
//  ---------+-------------+-------------+------------------------------------
//  in       | i_in_valid  | o_in_ready  | i_in_data  (op, payload_in)
//  out      | o_out_valid | i_out_ready | o_out_data (status, payload_out, item_count)
//
//  one operation per cycle while the output accepts; a beat passes the ram read stage, then
//  the output register, which holds its result until the out channel takes it
//  top, bottom and count update at accept and the ram read issues at the
//  same edge, so back-to-back ops always see fresh indices
//  synchronous active-low reset clears indices and valid flags, not the ram
//  a stalled output holds the read stage, and the input stalls behind it
// ----------------------------------------------------------------------------
module work_stealing_deque (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wsd_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wsd_pkg::t_out_item  o_out_data
);

    import wsd_pkg::*;

    // index state
    t_idx r_top, n_top;
    t_idx r_bot, n_bot;
    t_cnt r_count, n_count;

    // read stage: result waiting on the ram read data
    logic                r_s1_valid;
    logic                r_s1_rd, n_s1_rd;
    logic [STATUS_W-1:0] r_s1_status, n_s1_status;
    t_cnt                r_s1_count;

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    logic                     in_acc;
    logic                     s1_adv;
    logic                     ram_we;
    logic                     ram_re;
    t_addr                    ram_raddr;
    logic [PAYLOAD_WIDTH-1:0] ram_rdata;
    logic                     empty;
    logic                     full;

    assign empty = (r_count == '0);
    assign full  = (r_count == t_cnt'(CAPACITY));

    // read stage moves on when the output register is free or drains now
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // decode the op against the current indices
    always_comb begin
        n_top       = r_top;
        n_bot       = r_bot;
        n_count     = r_count;
        n_s1_rd     = 1'b0;
        n_s1_status = ST_DONE;
        ram_we      = 1'b0;
        ram_raddr   = slot_of(r_top);
        case (i_in_data.op)
            OP_PUSH: begin
                if (full) begin
                    n_s1_status = ST_FULL;
                end else begin
                    ram_we  = in_acc;
                    n_bot   = idx_inc(r_bot);
                    n_count = t_cnt'(r_count + 1'b1);
                end
            end
            OP_TAKE: begin
                if (empty) begin
                    n_s1_status = ST_EMPTY;
                end else begin
                    // newest item sits just below bottom
                    n_bot     = idx_dec(r_bot);
                    ram_raddr = slot_of(idx_dec(r_bot));
                    n_s1_rd   = 1'b1;
                    n_count   = t_cnt'(r_count - 1'b1);
                end
            end
            OP_STEAL: begin
                if (empty) begin
                    n_s1_status = ST_EMPTY;
                end else begin
                    n_top     = idx_inc(r_top);
                    ram_raddr = slot_of(r_top);
                    n_s1_rd   = 1'b1;
                    n_count   = t_cnt'(r_count - 1'b1);
                end
            end
            default: begin
                // unused op: nothing changes, done with current count
                n_s1_status = ST_DONE;
            end
        endcase
    end

    assign ram_re = in_acc && n_s1_rd;

    wsd_ram #(
        .WIDTH (PAYLOAD_WIDTH),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot_of(r_bot)),
        .i_wdata (i_in_data.payload_in[PAYLOAD_WIDTH-1:0]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_bot       <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_top   <= n_top;
                r_bot   <= n_bot;
                r_count <= n_count;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_rd     <= n_s1_rd;
            r_s1_status <= n_s1_status;
            r_s1_count  <= n_count;
        end
        if (s1_adv) begin
            r_out.status      <= r_s1_status;
            r_out.payload_out <= r_s1_rd ? DATA_W'(ram_rdata) : '0;
            r_out.item_count  <= ITEM_W'(r_s1_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // count stays within capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(CAPACITY))
        else $error("item count beyond capacity");

    // empty queue has equal indices
    a_empty_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_top == r_bot))
        else $error("empty queue with unequal indices");

    // accepted push with room grows the count by one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.op == OP_PUSH && !full)
        |=> (r_count == t_cnt'($past(r_count) + 1'b1)))
        else $error("push did not grow count");

    // stalled read stage holds its beat
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_count)
        && $stable(r_s1_status)))
        else $error("read stage lost a stalled beat");

endmodule

[src/wsd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module wsd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
